// ===== hdl/float_exp_polynomial_defines.svh =====
// ----------------------------------------------------------------------------
// float_exp_polynomial_defines.svh
// Assertion macros for the checker file of the exponential block.
// ----------------------------------------------------------------------------
`ifndef FLOAT_EXP_POLYNOMIAL_DEFINES_SVH
`define FLOAT_EXP_POLYNOMIAL_DEFINES_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define FEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion on clk_i that also holds during reset.
`define FEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/fep_pkg.sv =====
// ----------------------------------------------------------------------------
// fep_pkg
// Types, constants and single-precision arithmetic for the exponential pipe.
// ----------------------------------------------------------------------------
package fep_pkg;

  // Single-precision constants.
  localparam logic [31:0] ExpHi    = 32'h42B0_C0A5;
  localparam logic [31:0] ExpLo    = 32'hC2B0_C0A5;
  localparam logic [31:0] Log2E    = 32'h3FB8_AA3B;
  localparam logic [31:0] Ln2      = 32'h3F31_7218;
  localparam logic [31:0] FpHalf   = 32'h3F00_0000;
  localparam logic [31:0] FpOne    = 32'h3F80_0000;
  localparam logic [31:0] PolyC0   = 32'h3950_6967;
  localparam logic [31:0] PolyC1   = 32'h3AB7_43CE;
  localparam logic [31:0] PolyC2   = 32'h3C08_8908;
  localparam logic [31:0] PolyC3   = 32'h3D2A_A9C1;
  localparam logic [31:0] PolyC4   = 32'h3E2A_AAAA;
  localparam logic [31:0] PolyC5   = 32'h3F00_0000;
  localparam logic [31:0] QNanDef  = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam logic [8:0]  ExpBias  = 9'd127;

  // Pipeline stage codes.
  localparam int unsigned StClamp  = 0;
  localparam int unsigned StScale  = 1;
  localparam int unsigned StRound  = 2;
  localparam int unsigned StFloor  = 3;
  localparam int unsigned StToFlt  = 4;
  localparam int unsigned StRedMul = 5;
  localparam int unsigned StRedSub = 6;
  localparam int unsigned StSquare = 7;
  localparam int unsigned StAddC1  = 8;
  localparam int unsigned StMulY1  = 9;
  localparam int unsigned StAddC2  = 10;
  localparam int unsigned StMulY2  = 11;
  localparam int unsigned StAddC3  = 12;
  localparam int unsigned StMulY3  = 13;
  localparam int unsigned StAddC4  = 14;
  localparam int unsigned StMulY4  = 15;
  localparam int unsigned StAddC5  = 16;
  localparam int unsigned StMulZ   = 17;
  localparam int unsigned StAddY   = 18;
  localparam int unsigned StAddOne = 19;
  localparam int unsigned StPow2   = 20;
  localparam int unsigned NumStages = 21;

  // Data carried by one pipeline stage.
  typedef struct packed {
    logic [31:0]       y;
    logic [31:0]       t;
    logic [31:0]       z;
    logic signed [8:0] n;
  } stage_t;

  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] r;
    r = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) r = 6'(47 - i);
    end
    return r;
  endfunction

  function automatic logic [4:0] clz27(input logic [26:0] v);
    logic [4:0] r;
    r = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) r = 5'(26 - i);
    end
    return r;
  endfunction

  function automatic logic [3:0] clz9(input logic [8:0] v);
    logic [3:0] r;
    r = 4'd9;
    for (int i = 0; i < 9; i++) begin
      if (v[i]) r = 4'(8 - i);
    end
    return r;
  endfunction

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // Ordered less-than for operands that are not NaN.
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  // Round-to-nearest-even single-precision multiply with denormals.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sr;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        p, pn, ps;
    logic [5:0]         lz, sh;
    logic signed [10:0] er, shw;
    logic [7:0]         field;
    logic               stk, rnd;
    logic [30:0]        mag;
    logic [31:0]        r;
    sr  = a[31] ^ b[31];
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma  = {a[30:23] != 8'd0, a[22:0]};
    mb  = {b[30:23] != 8'd0, b[22:0]};
    p   = 48'(ma) * 48'(mb);
    lz  = clz48(p);
    pn  = p << lz;
    er  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126 - $signed({5'b0, lz});
    shw = 11'sd1 - er;
    sh  = (shw > 11'sd49) ? 6'd49 : shw[5:0];
    if (er < 11'sd1) begin
      ps    = pn >> sh;
      stk   = (ps << sh) != pn;
      field = 8'd0;
    end else begin
      ps    = pn;
      stk   = 1'b0;
      field = er[7:0];
    end
    rnd = ps[23] & (stk | (ps[22:0] != 23'd0) | ps[24]);
    mag = {field, ps[46:24]} + 31'(rnd);
    if (is_nan(a)) begin
      r = a | QuietBit;
    end else if (is_nan(b)) begin
      r = b | QuietBit;
    end else if ((is_inf(a) && (b[30:0] == 31'd0)) || (is_inf(b) && (a[30:0] == 31'd0))) begin
      r = QNanDef;
    end else if (is_inf(a) || is_inf(b)) begin
      r = {sr, 8'hFF, 23'd0};
    end else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
      r = {sr, 31'd0};
    end else if (er >= 11'sd255) begin
      r = {sr, 8'hFF, 23'd0};
    end else begin
      r = {sr, mag};
    end
    return r;
  endfunction

  // Round-to-nearest-even single-precision add with denormals.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml, r;
    logic [7:0]  eb, es, d;
    logic [5:0]  dc;
    logic [27:0] fa, fb, fbs, s, s2;
    logic [4:0]  lz, sh;
    logic [8:0]  e;
    logic [8:0]  field;
    logic        rnd;
    logic [30:0] mag;
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d   = eb - es;
    dc  = (d > 8'd31) ? 6'd31 : d[5:0];
    fa  = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b0};
    fb  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 3'b0};
    fbs = fb >> dc;
    fbs[0] = fbs[0] | ((fbs << dc) != fb);
    s   = (big[31] == sml[31]) ? (fa + fbs) : (fa - fbs);
    lz  = clz27(s[26:0]);
    if (s[27]) begin
      s2 = {1'b0, s[27:2], s[1] | s[0]};
      e  = {1'b0, eb} + 9'd1;
    end else begin
      sh = (9'(lz) > (9'(eb) - 9'd1)) ? 5'(eb - 8'd1) : lz;
      s2 = s << sh;
      e  = {1'b0, eb} - 9'(sh);
    end
    field = s2[26] ? e : 9'd0;
    rnd   = s2[2] & (s2[1] | s2[0] | s2[3]);
    mag   = {field[7:0], s2[25:3]} + 31'(rnd);
    if (is_nan(a)) begin
      r = a | QuietBit;
    end else if (is_nan(b)) begin
      r = b | QuietBit;
    end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
      r = QNanDef;
    end else if (is_inf(a)) begin
      r = a;
    end else if (is_inf(b)) begin
      r = b;
    end else if (s == 28'd0) begin
      r = {a[31] & b[31], 31'd0};
    end else if (field >= 9'd255) begin
      r = {big[31], 8'hFF, 23'd0};
    end else begin
      r = {big[31], mag};
    end
    return r;
  endfunction

  // Floor of a float whose magnitude stays below 256.
  function automatic logic signed [8:0] fp_floor(input logic [31:0] f);
    logic [7:0]  e, k8;
    logic [2:0]  k;
    logic [4:0]  sh;
    logic [23:0] m, ip;
    logic        fnz;
    logic [8:0]  mag;
    logic signed [8:0] r;
    e   = f[30:23];
    m   = {1'b1, f[22:0]};
    k8  = e - 8'd127;
    k   = k8[2:0];
    sh  = 5'd23 - {2'b0, k};
    ip  = m >> sh;
    fnz = (ip << sh) != m;
    mag = ip[8:0] + 9'(fnz);
    if (e < 8'd127) begin
      r = (f[31] && (f[30:0] != 31'd0)) ? -9'sd1 : 9'sd0;
    end else begin
      // A negative value with a fraction rounds away from zero, a positive one toward it.
      r = f[31] ? -$signed(mag) : $signed(ip[8:0]);
    end
    return r;
  endfunction

  // Exact conversion of a small integer to single precision.
  function automatic logic [31:0] int_to_fp(input logic signed [8:0] n);
    logic [8:0]  mag, mn;
    logic [3:0]  lz;
    logic [31:0] r;
    mag = n[8] ? 9'(-n) : 9'(n);
    lz  = clz9(mag);
    mn  = mag << lz;
    if (mag == 9'd0) begin
      r = 32'd0;
    end else begin
      r = {n[8], 8'd135 - 8'(lz), mn[7:0], 15'd0};
    end
    return r;
  endfunction

  // Work of one pipeline stage.
  function automatic stage_t stage_calc(input int unsigned idx, input stage_t s);
    stage_t     o;
    logic [31:0] cl;
    logic [8:0]  ef;
    o  = s;
    cl = (!is_nan(s.y) && fp_lt(s.y, ExpHi)) ? s.y : ExpHi;
    ef = s.n + ExpBias;
    case (idx)
      StClamp:  o.y = fp_lt(ExpLo, cl) ? cl : ExpLo;
      StScale:  o.t = fp_mul(s.y, Log2E);
      StRound:  o.t = fp_add(s.t, FpHalf);
      StFloor:  o.n = fp_floor(s.t);
      StToFlt:  o.t = int_to_fp(s.n);
      StRedMul: o.t = fp_mul(s.t, Ln2);
      StRedSub: o.y = fp_add(s.y, {~s.t[31], s.t[30:0]});
      StSquare: begin
        o.z = fp_mul(s.y, s.y);
        o.t = fp_mul(PolyC0, s.y);
      end
      StAddC1:  o.t = fp_add(s.t, PolyC1);
      StMulY1:  o.t = fp_mul(s.t, s.y);
      StAddC2:  o.t = fp_add(s.t, PolyC2);
      StMulY2:  o.t = fp_mul(s.t, s.y);
      StAddC3:  o.t = fp_add(s.t, PolyC3);
      StMulY3:  o.t = fp_mul(s.t, s.y);
      StAddC4:  o.t = fp_add(s.t, PolyC4);
      StMulY4:  o.t = fp_mul(s.t, s.y);
      StAddC5:  o.t = fp_add(s.t, PolyC5);
      StMulZ:   o.t = fp_mul(s.t, s.z);
      StAddY:   o.t = fp_add(s.t, s.y);
      StAddOne: o.t = fp_add(s.t, FpOne);
      StPow2:   o.t = fp_mul(s.t, {ef[8], ef[7:0], 23'd0});
      default:  o = s;
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/float_exp_polynomial.sv =====
// ----------------------------------------------------------------------------
// float_exp_polynomial
// Pipelined single-precision exponential: range reduction by ln2, a degree-7
// polynomial, and scaling by a power of two built from the exponent field.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  input     in         valid_i / stall_o  x_bits_i
//  result    out        valid_o / stall_i  result_bits_o
//
//  One item enters per clock while stall_o is low.
//  The pipe has 21 stages; most do one float multiply or add.
//  Reset empties the pipe; data registers are not reset.
//  A result held by stall_i freezes the whole pipe, and stall_o follows it.
module float_exp_polynomial (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] x_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] result_bits_o
);
  import fep_pkg::*;

  logic                 adv;
  logic [NumStages-1:0] vld_q;
  stage_t               dat_q [NumStages];
  stage_t               dat_d [NumStages];
  stage_t               in_stage;

  // The pipe moves unless a finished result waits on the output.
  assign adv     = !(vld_q[NumStages-1] && stall_i);
  assign stall_o = !adv;

  always_comb begin
    in_stage   = '0;
    in_stage.y = x_bits_i;
  end

  // Stage logic.
  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb dat_d[k] = stage_calc(k, in_stage);
    end else begin : g_rest
      always_comb dat_d[k] = stage_calc(k, dat_q[k-1]);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumStages; i++) begin
        dat_q[i] <= dat_d[i];
      end
    end
  end

  assign valid_o       = vld_q[NumStages-1];
  assign result_bits_o = dat_q[NumStages-1].t;

endmodule

// ===== hdl/fep_checker.sv =====
// ----------------------------------------------------------------------------
// fep_checker
// Port-level checks on the exponential pipeline, bound to its top level.
// ----------------------------------------------------------------------------
`include "float_exp_polynomial_defines.svh"

module fep_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] result_bits_o
);

  // Nothing is offered while reset holds.
  `FEP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !valid_o, "result valid during reset")

  // The input side waits only behind a result held at the output.
  `FEP_ASSERT(a_stall_cause, stall_o |-> (valid_o && stall_i), "input stalled without cause")

  // A held result stays offered and unchanged.
  `FEP_ASSERT(a_hold, (valid_o && stall_i) |=> (valid_o && $stable(result_bits_o)),
              "held result changed")

endmodule

bind float_exp_polynomial fep_checker u_fep_checker (.*);
